// ===== sv/conv3x3_clamp_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution filter
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_CLAMP_FILTER_UNIT_ASSERT_SVH
`define CONV3X3_CLAMP_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset
`define C3CF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge
`define C3CF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define C3CF_ASSERT(lbl, clk, rst_n, prop, msg)
`define C3CF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== sv/c3cf_pkg.sv =====
// ----------------------------------------------------------------------------
// c3cf_pkg
// Constants, types and helpers of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c3cf_pkg;

  // Geometry and field widths
  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned PixW            = 8;
  localparam int unsigned CfgWidthW       = 11;
  localparam int unsigned CfgHeightW      = 12;
  localparam int unsigned RowCntW         = 12;
  localparam int unsigned CfgIndexW       = 3;
  localparam int unsigned CfgDataW        = 48;
  localparam int unsigned WeightW         = 16;
  localparam int unsigned WeightFracBits  = 14;
  localparam int unsigned TapsPerRow      = 3;

  // Arithmetic widths: 9-bit signed pixel times 16-bit weight, then sums of 3 and 9
  localparam int unsigned ProdW = PixW + 1 + WeightW;
  localparam int unsigned RsumW = ProdW + 2;
  localparam int unsigned SumW  = RsumW + 2;

  // Result queue
  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  // Reset values of the registers
  localparam logic [CfgWidthW-1:0]  FrameWidthReset  = CfgWidthW'(640);
  localparam logic [CfgHeightW-1:0] FrameHeightReset = CfgHeightW'(480);

  // Register indexes of the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    REG_FRAME_WIDTH  = CfgIndexW'(0),
    REG_FRAME_HEIGHT = CfgIndexW'(1),
    REG_WEIGHTS_ROW0 = CfgIndexW'(2),
    REG_WEIGHTS_ROW1 = CfgIndexW'(3),
    REG_WEIGHTS_ROW2 = CfgIndexW'(4)
  } cfg_reg_e;

  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic signed [ProdW-1:0]   prod_t;
  typedef logic signed [RsumW-1:0]   rsum_t;
  typedef logic signed [SumW-1:0]    sum_t;

  // Per-item markers carried down the pipeline
  typedef struct packed {
    logic emit;
    logic eor;
    logic eof;
  } tag_t;

  // One queued result
  typedef struct packed {
    logic            eof;
    logic            eor;
    logic [PixW-1:0] pixel;
  } out_beat_t;

  // Drop the fraction and clamp to the pixel range
  function automatic logic [PixW-1:0] clamp_pixel(input sum_t acc);
    sum_t shifted;
    shifted = acc >>> WeightFracBits;
    if (acc <= sum_t'(0)) begin
      return '0;
    end else if (shifted > sum_t'((1 << PixW) - 1)) begin
      return '1;
    end else begin
      return shifted[PixW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/conv3x3_clamp_filter_unit.sv =====
// ----------------------------------------------------------------------------
// conv3x3_clamp_filter_unit
// 3x3 convolution over a raster pixel stream, truncated and clamped to 8 bits.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one grey pixel per beat (tdata), tuser marks the first pixel of a
//   frame and restarts the row and column counts. m_axis: one beat for each
//   pixel of the valid region ((H-2) x (W-2)), tlast on the last beat of an
//   output row, tuser on the last beat of the frame.
//   cfg: index/data writes to frame_width (0), frame_height (1) and the three
//   packed weight rows (2..4); cfg_ready_o is always high. Write only while
//   no pixel is in flight. Other indexes are ignored.
// Timing:
//   One pixel per cycle sustained while s_axis_tready is high. A result beat is
//   registered in order through line memory read and nine products, row sums,
//   then total and clamp into an 8-entry result queue.
//   s_axis_tready drops only when queued plus in-flight beats reach the queue
//   depth, so the input keeps flowing while a result waits to be taken; a
//   long stall on m_axis fills the queue and then holds the input off.
// Reset:
//   Counters, pipeline and queue clear, width 640, height 480, weights zero.
//   The line memory is not cleared; entries are written before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "conv3x3_clamp_filter_unit_assert.svh"

module conv3x3_clamp_filter_unit #(
  parameter int unsigned MaxWidth = c3cf_pkg::MaxWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Pixel input
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [c3cf_pkg::PixW-1:0]      s_axis_tdata,  // [7:0] pixel
  input  wire logic [0:0]                     s_axis_tuser,  // [0] start_of_frame
  // Filtered output
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [c3cf_pkg::PixW-1:0]           m_axis_tdata,  // [7:0] filtered
  output logic                                m_axis_tlast,  // end_of_row
  output logic [0:0]                          m_axis_tuser,  // [0] end_of_frame
  // Configuration writes
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [c3cf_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [c3cf_pkg::CfgDataW-1:0]  cfg_data_i
);

  import c3cf_pkg::*;

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned MemW = 2 * PixW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CfgWidthW-1:0]                 cfg_width_q;
  logic [CfgHeightW-1:0]                cfg_height_q;
  logic [TapsPerRow-1:0][CfgDataW-1:0]  cfg_weights_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q   <= FrameWidthReset;
      cfg_height_q  <= FrameHeightReset;
      cfg_weights_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_width_q      <= cfg_data_i[CfgWidthW-1:0];
        REG_FRAME_HEIGHT: cfg_height_q     <= cfg_data_i[CfgHeightW-1:0];
        REG_WEIGHTS_ROW0: cfg_weights_q[0] <= cfg_data_i;
        REG_WEIGHTS_ROW1: cfg_weights_q[1] <= cfg_data_i;
        REG_WEIGHTS_ROW2: cfg_weights_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Position tracking at the input beat
  // --------------------------------------------------------------------------
  logic                 in_acc;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowCntW-1:0]   row_q, row_d;
  logic [ColW-1:0]      w_last;
  logic [CfgHeightW-1:0] h_last;
  logic [ColW-1:0]      c0;
  logic [RowCntW-1:0]   r0;
  tag_t                 tag0;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Last column and last row, with out-of-range sizes pulled into range
  always_comb begin
    if (cfg_width_q < CfgWidthW'(3)) begin
      w_last = ColW'(2);
    end else if (32'(cfg_width_q) > MaxWidth) begin
      w_last = ColW'(MaxWidth - 1);
    end else begin
      w_last = ColW'(cfg_width_q - CfgWidthW'(1));
    end
    if (cfg_height_q < CfgHeightW'(3)) begin
      h_last = CfgHeightW'(2);
    end else begin
      h_last = cfg_height_q - CfgHeightW'(1);
    end
  end

  // Column and row of the incoming pixel, and its output markers
  always_comb begin
    if (s_axis_tuser[0]) begin
      c0 = '0;
      r0 = '0;
    end else begin
      c0 = (col_q >= w_last) ? w_last : col_q;
      r0 = row_q;
    end
    tag0.eor  = (c0 == w_last);
    tag0.eof  = tag0.eor && (r0 >= h_last);
    tag0.emit = (r0 >= RowCntW'(2)) && (c0 >= ColW'(2));
  end

  // Next position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_acc) begin
      if (tag0.eor) begin
        col_d = '0;
        row_d = (r0 >= h_last) ? '0 : r0 + RowCntW'(1);
      end else begin
        col_d = c0 + ColW'(1);
        row_d = r0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line memory: each word holds {two rows up, one row up} for a column
  // --------------------------------------------------------------------------
  logic [MemW-1:0] line_mem_q [MaxWidth];
  logic [MemW-1:0] rd_data_q;
  logic [MemW-1:0] wr_data;
  logic            wr_en;
  logic [ColW-1:0] c1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem_q[c1_q] <= wr_data;
    end
    rd_data_q <= line_mem_q[c0];
  end

  // --------------------------------------------------------------------------
  // Stage 1: memory data arrives, window shifts, products formed
  // --------------------------------------------------------------------------
  logic             v1_q;
  logic [PixW-1:0]  pix1_q;
  tag_t             tag1_q;
  logic             byp_q;
  logic [MemW-1:0]  byp_data_q;
  logic [PixW-1:0]  older_eff, newer_eff;
  logic [PixW-1:0]  win_q [2*TapsPerRow];
  logic [PixW-1:0]  col_cur [TapsPerRow];
  prod_t            prod_d [TapsPerRow*TapsPerRow];
  prod_t            prod_q [TapsPerRow*TapsPerRow];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      byp_q <= 1'b0;
    end else begin
      v1_q  <= in_acc;
      // Same column written by the item ahead while this one reads
      byp_q <= in_acc && v1_q && (c0 == c1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      c1_q   <= c0;
      pix1_q <= s_axis_tdata;
      tag1_q <= tag0;
    end
    byp_data_q <= wr_data;
  end

  // Forward the write of the previous item on a read-during-write
  always_comb begin
    older_eff  = byp_q ? byp_data_q[MemW-1:PixW] : rd_data_q[MemW-1:PixW];
    newer_eff  = byp_q ? byp_data_q[PixW-1:0]    : rd_data_q[PixW-1:0];
    wr_en      = v1_q;
    wr_data    = {newer_eff, pix1_q};
    col_cur[0] = pix1_q;
    col_cur[1] = newer_eff;
    col_cur[2] = older_eff;
  end

  // Two past columns of the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2 * TapsPerRow; i++) begin
        win_q[i] <= '0;
      end
    end else if (v1_q) begin
      for (int m = 0; m < TapsPerRow; m++) begin
        win_q[TapsPerRow + m] <= win_q[m];
        win_q[m]              <= col_cur[m];
      end
    end
  end

  // Nine independent products, pixel(r-m, c-n) times weight[m][n]
  always_comb begin
    logic [PixW-1:0] px;
    weight_t         wgt;
    for (int m = 0; m < TapsPerRow; m++) begin
      for (int n = 0; n < TapsPerRow; n++) begin
        case (n)
          0:       px = col_cur[m];
          1:       px = win_q[m];
          default: px = win_q[TapsPerRow + m];
        endcase
        wgt = weight_t'(cfg_weights_q[m][WeightW*n +: WeightW]);
        prod_d[TapsPerRow*m + n] = $signed({1'b0, px}) * wgt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products registered, kernel row sums formed
  // --------------------------------------------------------------------------
  logic  v2_q;
  tag_t  tag2_q;
  rsum_t rsum_d [TapsPerRow];
  rsum_t rsum_q [TapsPerRow];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= tag1_q;
    for (int i = 0; i < TapsPerRow * TapsPerRow; i++) begin
      prod_q[i] <= prod_d[i];
    end
  end

  always_comb begin
    for (int m = 0; m < TapsPerRow; m++) begin
      rsum_d[m] = rsum_t'(prod_q[TapsPerRow*m]) + rsum_t'(prod_q[TapsPerRow*m + 1])
                + rsum_t'(prod_q[TapsPerRow*m + 2]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: row sums registered, total and clamp into the result queue
  // --------------------------------------------------------------------------
  logic      v3_q;
  tag_t      tag3_q;
  sum_t      total;
  out_beat_t beat_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag3_q <= tag2_q;
    for (int m = 0; m < TapsPerRow; m++) begin
      rsum_q[m] <= rsum_d[m];
    end
  end

  always_comb begin
    total        = sum_t'(rsum_q[0]) + sum_t'(rsum_q[1]) + sum_t'(rsum_q[2]);
    beat_d.pixel = clamp_pixel(total);
    beat_d.eor   = tag3_q.eor;
    beat_d.eof   = tag3_q.eof;
  end

  // --------------------------------------------------------------------------
  // Result queue; input credit counts queued and in-flight beats
  // --------------------------------------------------------------------------
  out_beat_t          fifo_q [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    fifo_cnt_q, fifo_cnt_d;
  logic [CntW-1:0]    credit_used;
  logic               fifo_push, fifo_pop;
  out_beat_t          head;

  assign fifo_push   = v3_q && tag3_q.emit;
  assign fifo_pop    = m_axis_tvalid && m_axis_tready;
  assign credit_used = fifo_cnt_q + CntW'(v1_q) + CntW'(v2_q) + CntW'(v3_q);
  assign s_axis_tready = (credit_used < CntW'(FifoDepth));

  always_comb begin
    fifo_cnt_d = fifo_cnt_q + CntW'(fifo_push) - CntW'(fifo_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (fifo_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[wr_ptr_q] <= beat_d;
    end
  end

  assign head            = fifo_q[rd_ptr_q];
  assign m_axis_tvalid   = (fifo_cnt_q != '0);
  assign m_axis_tdata    = head.pixel;
  assign m_axis_tlast    = head.eor;
  assign m_axis_tuser[0] = head.eof;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `C3CF_ASSERT(a_credit_bound, clk_i, rst_ni, credit_used <= CntW'(FifoDepth), "credit overrun")
  `C3CF_ASSERT(a_push_room, clk_i, rst_ni, !fifo_push || (fifo_cnt_q < CntW'(FifoDepth)), "queue overflow")
  `C3CF_ASSERT_NEXT(a_sof_restart, clk_i, rst_ni, in_acc && s_axis_tuser[0], col_q == ColW'(1), "frame start did not restart column")

endmodule

`default_nettype wire
